[hdl/mexp_pkg.sv]
package mexp_pkg;

    localparam int unsigned VAL_W = 30;
    localparam int unsigned EXP_W = 63;
    localparam int unsigned CNT_W = 6;
    localparam int unsigned UPC_W = 4;
    localparam int unsigned MUL_W = 32;

    localparam logic [VAL_W-1:0] PRIME      = 30'd1000000007;
    localparam logic [MUL_W-1:0] PRIME_WIDE = 32'd1000000007;
    // floor(2^60 / PRIME)
    localparam logic [MUL_W-1:0] BARRETT_MU = 32'd1152921496;
    localparam logic [CNT_W-1:0] LAST_BIT   = 6'd62;

    typedef logic [UPC_W-1:0] upc_t;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD,
        ACT_LEAD,
        ACT_MUL_SQ,
        ACT_MUL_BASE,
        ACT_MUL_MU,
        ACT_MUL_P,
        ACT_SUB,
        ACT_FIX,
        ACT_FIX_ACC,
        ACT_SHIFT,
        ACT_EMIT
    } act_t;

    typedef enum logic [2:0] {
        JMP_NONE,
        JMP_NOFIRE,
        JMP_ONE,
        JMP_BITCLR,
        JMP_MORE,
        JMP_OUTFULL
    } jmp_t;

    typedef struct packed {
        act_t act;
        jmp_t jmp;
        upc_t target;
        logic take;
    } uword_t;

    typedef struct packed {
        logic one;
        logic bit_set;
        logic more;
    } dstat_t;

    localparam upc_t UPC_IDLE  = 4'd0;
    localparam upc_t UPC_BIT   = 4'd1;
    localparam upc_t UPC_NEXT  = 4'd14;
    localparam upc_t UPC_EMIT  = 4'd15;

    function automatic uword_t ucode(input upc_t addr);
        uword_t w;
        w = '{act: ACT_NONE, jmp: JMP_NONE, target: UPC_IDLE, take: 1'b0};
        unique case (addr)
            4'd0:  w = '{act: ACT_LOAD,     jmp: JMP_NOFIRE,  target: UPC_IDLE, take: 1'b1};
            4'd1:  w = '{act: ACT_LEAD,     jmp: JMP_ONE,     target: UPC_NEXT, take: 1'b0};
            4'd2:  w = '{act: ACT_MUL_SQ,   jmp: JMP_NONE,    target: UPC_IDLE, take: 1'b0};
            4'd3:  w = '{act: ACT_MUL_MU,   jmp: JMP_NONE,    target: UPC_IDLE, take: 1'b0};
            4'd4:  w = '{act: ACT_MUL_P,    jmp: JMP_NONE,    target: UPC_IDLE, take: 1'b0};
            4'd5:  w = '{act: ACT_SUB,      jmp: JMP_NONE,    target: UPC_IDLE, take: 1'b0};
            4'd6:  w = '{act: ACT_FIX,      jmp: JMP_NONE,    target: UPC_IDLE, take: 1'b0};
            4'd7:  w = '{act: ACT_FIX_ACC,  jmp: JMP_BITCLR,  target: UPC_NEXT, take: 1'b0};
            4'd8:  w = '{act: ACT_MUL_BASE, jmp: JMP_NONE,    target: UPC_IDLE, take: 1'b0};
            4'd9:  w = '{act: ACT_MUL_MU,   jmp: JMP_NONE,    target: UPC_IDLE, take: 1'b0};
            4'd10: w = '{act: ACT_MUL_P,    jmp: JMP_NONE,    target: UPC_IDLE, take: 1'b0};
            4'd11: w = '{act: ACT_SUB,      jmp: JMP_NONE,    target: UPC_IDLE, take: 1'b0};
            4'd12: w = '{act: ACT_FIX,      jmp: JMP_NONE,    target: UPC_IDLE, take: 1'b0};
            4'd13: w = '{act: ACT_FIX_ACC,  jmp: JMP_NONE,    target: UPC_IDLE, take: 1'b0};
            4'd14: w = '{act: ACT_SHIFT,    jmp: JMP_MORE,    target: UPC_BIT,  take: 1'b0};
            4'd15: w = '{act: ACT_EMIT,     jmp: JMP_OUTFULL, target: UPC_EMIT, take: 1'b0};
        endcase
        return w;
    endfunction

endpackage

[hdl/mexp_seq.sv]
module mexp_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic              out_full,
    input  mexp_pkg::dstat_t  st,
    output mexp_pkg::uword_t  cw
);

    mexp_pkg::upc_t upc_reg;
    mexp_pkg::upc_t upc_next;
    logic           jump;

    always_comb
    begin
        cw = mexp_pkg::ucode(upc_reg);
    end

    always_comb
    begin
        unique case (cw.jmp)
            mexp_pkg::JMP_NONE:    jump = 1'b0;
            mexp_pkg::JMP_NOFIRE:  jump = !fire;
            mexp_pkg::JMP_ONE:     jump = st.one;
            mexp_pkg::JMP_BITCLR:  jump = !st.bit_set;
            mexp_pkg::JMP_MORE:    jump = st.more;
            mexp_pkg::JMP_OUTFULL: jump = out_full;
            default:               jump = 1'b0;
        endcase
        upc_next = jump ? cw.target : upc_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= mexp_pkg::UPC_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

[hdl/mexp_datapath.sv]
module mexp_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mexp_pkg::uword_t                cw,
    input  logic                            fire,
    input  logic                            out_full,
    input  logic                            out_ready,
    input  logic [mexp_pkg::VAL_W-1:0]      base,
    input  logic [mexp_pkg::EXP_W-1:0]      exponent,
    output mexp_pkg::dstat_t                st,
    output logic                            out_valid,
    output logic [mexp_pkg::VAL_W-1:0]      power
);

    logic [29:0] acc_reg,   acc_next;
    logic [29:0] base_reg,  base_next;
    logic [62:0] exp_reg,   exp_next;
    logic [5:0]  cnt_reg,   cnt_next;
    logic        one_reg,   one_next;
    logic [31:0] x_reg,     x_next;
    logic [63:0] prod_reg,  prod_next;
    logic [31:0] r_reg,     r_next;
    logic        out_valid_reg, out_valid_next;
    logic [29:0] power_reg, power_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;
    logic [31:0] r_fix;
    logic [29:0] base_red;

    // select multiplier operands
    always_comb
    begin
        unique case (cw.act)
            mexp_pkg::ACT_MUL_SQ:
            begin
                mul_a = {2'b00, acc_reg};
                mul_b = {2'b00, acc_reg};
            end
            mexp_pkg::ACT_MUL_BASE:
            begin
                mul_a = {2'b00, acc_reg};
                mul_b = {2'b00, base_reg};
            end
            mexp_pkg::ACT_MUL_MU:
            begin
                mul_a = {1'b0, prod_reg[59:29]};
                mul_b = mexp_pkg::BARRETT_MU;
            end
            mexp_pkg::ACT_MUL_P:
            begin
                mul_a = {1'b0, prod_reg[61:31]};
                mul_b = mexp_pkg::PRIME_WIDE;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
        mul_p = {32'd0, mul_a} * {32'd0, mul_b};
    end

    always_comb
    begin
        r_fix    = (r_reg >= mexp_pkg::PRIME_WIDE) ? r_reg - mexp_pkg::PRIME_WIDE : r_reg;
        base_red = (base >= mexp_pkg::PRIME) ? base - mexp_pkg::PRIME : base;
    end

    always_comb
    begin
        acc_next       = acc_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        cnt_next       = cnt_reg;
        one_next       = one_reg;
        x_next         = x_reg;
        prod_next      = prod_reg;
        r_next         = r_reg;
        out_valid_next = out_valid_reg && !out_ready;
        power_next     = power_reg;
        unique case (cw.act)
            mexp_pkg::ACT_LOAD:
            begin
                if (fire)
                begin
                    acc_next  = 30'd1;
                    base_next = base_red;
                    exp_next  = exponent;
                    cnt_next  = mexp_pkg::LAST_BIT;
                    one_next  = 1'b1;
                end
            end
            mexp_pkg::ACT_LEAD:
            begin
                // first set bit: 1 * base needs no multiply
                if (one_reg && exp_reg[62])
                begin
                    acc_next = base_reg;
                    one_next = 1'b0;
                end
            end
            mexp_pkg::ACT_MUL_SQ, mexp_pkg::ACT_MUL_BASE, mexp_pkg::ACT_MUL_P:
            begin
                prod_next = mul_p;
            end
            mexp_pkg::ACT_MUL_MU:
            begin
                x_next    = prod_reg[31:0];
                prod_next = mul_p;
            end
            mexp_pkg::ACT_SUB:
            begin
                r_next = x_reg - prod_reg[31:0];
            end
            mexp_pkg::ACT_FIX:
            begin
                r_next = r_fix;
            end
            mexp_pkg::ACT_FIX_ACC:
            begin
                acc_next = (r_fix >= mexp_pkg::PRIME_WIDE) ?
                           30'(r_fix - mexp_pkg::PRIME_WIDE) : r_fix[29:0];
            end
            mexp_pkg::ACT_SHIFT:
            begin
                exp_next = {exp_reg[61:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
            end
            mexp_pkg::ACT_EMIT:
            begin
                if (!out_full)
                begin
                    out_valid_next = 1'b1;
                    power_next     = acc_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            one_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            one_reg       <= one_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        base_reg  <= base_next;
        exp_reg   <= exp_next;
        x_reg     <= x_next;
        prod_reg  <= prod_next;
        r_reg     <= r_next;
        power_reg <= power_next;
    end

    assign st.one     = one_reg;
    assign st.bit_set = exp_reg[62];
    assign st.more    = (cnt_reg != 6'd0);
    assign out_valid  = out_valid_reg;
    assign power      = power_reg;

endmodule

[hdl/modular_exponentiation_top.sv]
// Modular exponentiation: power = base ** exponent mod 1000000007.
// Input channel: in_valid / in_ready with base (30 bits, expected below the
// modulus; a larger value is reduced once) and exponent (63 bits).
// Output channel: out_valid / out_ready with power (30 bits).
// One item in, one item out; items are processed one at a time.
// A small microcode table steps one 32x32 multiplier through square,
// optional multiply by base, and Barrett reduction, scanning the exponent
// from bit 62 down. Bits up to and including the first set bit need no
// multiply; after it, a clear bit takes a square and a reduction, and a
// set bit also a multiply by base and a second reduction. A new item is
// taken only after the last result is handed to the output register.
// in_ready is high only while the sequencer waits for a new item. The
// result sits in an output register, so the next item is taken while it
// waits; if the receiver stalls past the next result, the sequencer holds
// that result until the register frees up.
// Reset clears the sequencer and output valid; no clearing pass is needed.
module modular_exponentiation_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [mexp_pkg::VAL_W-1:0]  base,
    input  logic [mexp_pkg::EXP_W-1:0]  exponent,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [mexp_pkg::VAL_W-1:0]  power
);

    mexp_pkg::uword_t cw;
    mexp_pkg::dstat_t st;
    logic             fire;
    logic             out_full;

    assign in_ready = cw.take;
    assign fire     = in_valid && in_ready;
    assign out_full = out_valid && !out_ready;

    mexp_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .out_full (out_full),
        .st       (st),
        .cw       (cw)
    );

    mexp_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cw        (cw),
        .fire      (fire),
        .out_full  (out_full),
        .out_ready (out_ready),
        .base      (base),
        .exponent  (exponent),
        .st        (st),
        .out_valid (out_valid),
        .power     (power)
    );

endmodule

[hdl/mexp_checker.sv]
module mexp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [mexp_pkg::VAL_W-1:0]  power
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(power))
        else $error("output item changed while stalled");

    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> power < mexp_pkg::PRIME)
        else $error("power not reduced");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken in back-to-back cycles");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared right after accept");

endmodule

bind modular_exponentiation_top mexp_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .power     (power)
);
